/* design/yba_pkg.sv */
`default_nettype none

package yba_pkg;

	localparam int CoefFracBits = 14;

	// widths of the fixed-point intermediates
	localparam int CoefW   = CoefFracBits + 2;    // signed coefficient
	localparam int DataW   = CoefFracBits + 10;   // Y, R-Y, B-Y (F fraction bits)
	localparam int ProdW   = CoefW + DataW;       // coefficient * difference
	localparam int AccW    = ProdW + 1;           // sum of two products
	localparam int ChromaW = AccW - CoefFracBits; // I, Q after floor
	localparam int ScaledW = DataW + CoefFracBits; // Y with 2F fraction bits
	localparam int MixW    = CoefW + ChromaW;     // coefficient * chroma
	localparam int SumW    = MixW + 2;            // channel sum, 2F fraction bits

	localparam int PipeDepth = 5;

	// round(thousandths / 1000 * 2^F), ties up
	function automatic int fx_coef(input int thousandths);
		return (thousandths * (1 << CoefFracBits) + 500) / 1000;
	endfunction

	localparam logic signed [CoefW-1:0] CoefYR = CoefW'(fx_coef(299));
	localparam logic signed [CoefW-1:0] CoefYG = CoefW'(fx_coef(587));
	localparam logic signed [CoefW-1:0] CoefYB = CoefW'(fx_coef(114));
	localparam logic signed [CoefW-1:0] CoefIR = CoefW'(fx_coef(710));
	localparam logic signed [CoefW-1:0] CoefIB = CoefW'(fx_coef(270));
	localparam logic signed [CoefW-1:0] CoefQR = CoefW'(fx_coef(480));
	localparam logic signed [CoefW-1:0] CoefQB = CoefW'(fx_coef(410));
	localparam logic signed [CoefW-1:0] CoefRI = CoefW'(fx_coef(956));
	localparam logic signed [CoefW-1:0] CoefRQ = CoefW'(fx_coef(620));
	localparam logic signed [CoefW-1:0] CoefGI = CoefW'(fx_coef(272));
	localparam logic signed [CoefW-1:0] CoefGQ = CoefW'(fx_coef(647));
	localparam logic signed [CoefW-1:0] CoefBI = CoefW'(fx_coef(1108));
	localparam logic signed [CoefW-1:0] CoefBQ = CoefW'(fx_coef(1705));

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       last_in;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last_out;
	} result_t;

	typedef struct packed {
		logic signed [DataW-1:0]   luma;
		logic signed [ChromaW-1:0] chroma_i;
		logic signed [ChromaW-1:0] chroma_q;
		logic                      last;
	} yiq_t;

endpackage

`default_nettype wire

/* design/yba_fwd.sv */
`default_nettype none

// RGB -> YIQ, three register stages
module yba_fwd (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pix_valid,
	output logic               pix_ready,
	input  wire yba_pkg::pixel_t pix,
	output logic               yiq_valid,
	input  wire logic          yiq_ready,
	output yba_pkg::yiq_t      yiq
);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [yba_pkg::DataW-1:0] luma_w;
	logic signed [yba_pkg::DataW-1:0] luma_s1, luma_s2;
	logic [7:0] red_s1, blue_s1;
	logic last_s1, last_s2;

	logic signed [yba_pkg::DataW-1:0] ry_w, by_w;
	logic signed [yba_pkg::ProdW-1:0] p_ir_s2, p_ib_s2, p_qr_s2, p_qb_s2;

	logic signed [yba_pkg::AccW-1:0] isum_w, qsum_w;
	yba_pkg::yiq_t yiq_s3;

	assign rdy_s3    = !v_s3 || yiq_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign pix_ready = rdy_s1;

	assign luma_w =
		yba_pkg::DataW'(yba_pkg::CoefYR) * yba_pkg::DataW'($signed({1'b0, pix.red_in}))
		+ yba_pkg::DataW'(yba_pkg::CoefYG) * yba_pkg::DataW'($signed({1'b0, pix.green_in}))
		+ yba_pkg::DataW'(yba_pkg::CoefYB) * yba_pkg::DataW'($signed({1'b0, pix.blue_in}));

	assign ry_w = (yba_pkg::DataW'($signed({1'b0, red_s1})) <<< yba_pkg::CoefFracBits)
		- luma_s1;
	assign by_w = (yba_pkg::DataW'($signed({1'b0, blue_s1})) <<< yba_pkg::CoefFracBits)
		- luma_s1;

	assign isum_w = yba_pkg::AccW'(p_ir_s2) - yba_pkg::AccW'(p_ib_s2);
	assign qsum_w = yba_pkg::AccW'(p_qr_s2) + yba_pkg::AccW'(p_qb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pix_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pix_valid) begin
			luma_s1 <= luma_w;
			red_s1  <= pix.red_in;
			blue_s1 <= pix.blue_in;
			last_s1 <= pix.last_in;
		end
		if (rdy_s2 && v_s1) begin
			p_ir_s2 <= yba_pkg::ProdW'(ry_w) * yba_pkg::ProdW'(yba_pkg::CoefIR);
			p_ib_s2 <= yba_pkg::ProdW'(by_w) * yba_pkg::ProdW'(yba_pkg::CoefIB);
			p_qr_s2 <= yba_pkg::ProdW'(ry_w) * yba_pkg::ProdW'(yba_pkg::CoefQR);
			p_qb_s2 <= yba_pkg::ProdW'(by_w) * yba_pkg::ProdW'(yba_pkg::CoefQB);
			luma_s2 <= luma_s1;
			last_s2 <= last_s1;
		end
		if (rdy_s3 && v_s2) begin
			// arithmetic shift floors toward minus infinity
			yiq_s3.luma     <= luma_s2;
			yiq_s3.chroma_i <= yba_pkg::ChromaW'(isum_w >>> yba_pkg::CoefFracBits);
			yiq_s3.chroma_q <= yba_pkg::ChromaW'(qsum_w >>> yba_pkg::CoefFracBits);
			yiq_s3.last     <= last_s2;
		end
	end

	assign yiq_valid = v_s3;
	assign yiq       = yiq_s3;

endmodule

`default_nettype wire

/* design/yba_inv.sv */
`default_nettype none

// luma offset and YIQ -> RGB with clamp, two register stages
module yba_inv (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 yiq_valid,
	output logic                      yiq_ready,
	input  wire yba_pkg::yiq_t        yiq,
	input  wire logic signed [7:0]    offset,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output yba_pkg::result_t          res
);

	logic v_s4, v_s5;
	logic rdy_s4, rdy_s5;

	logic signed [yba_pkg::DataW-1:0]   base_w;
	logic signed [yba_pkg::ScaledW-1:0] ys_s4;
	logic signed [yba_pkg::MixW-1:0] m_ri_s4, m_rq_s4, m_gi_s4, m_gq_s4, m_bi_s4, m_bq_s4;
	logic last_s4;

	logic signed [yba_pkg::SumW-1:0] sum_r_w, sum_g_w, sum_b_w;
	yba_pkg::result_t res_s5;

	// drop 2F fraction bits; negative gives 0, above 255 saturates
	function automatic logic [7:0] clamp_channel(input logic signed [yba_pkg::SumW-1:0] v);
		logic [7:0] c;
		if (v[yba_pkg::SumW-1])
			c = 8'd0;
		else if (|v[yba_pkg::SumW-2:2*yba_pkg::CoefFracBits+8])
			c = 8'hFF;
		else
			c = v[2*yba_pkg::CoefFracBits+7:2*yba_pkg::CoefFracBits];
		return c;
	endfunction

	assign rdy_s5    = !v_s5 || res_ready;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign yiq_ready = rdy_s4;

	assign base_w = yiq.luma
		+ (yba_pkg::DataW'(offset) <<< yba_pkg::CoefFracBits);

	assign sum_r_w = yba_pkg::SumW'(ys_s4) + yba_pkg::SumW'(m_ri_s4)
		+ yba_pkg::SumW'(m_rq_s4);
	assign sum_g_w = yba_pkg::SumW'(ys_s4) - yba_pkg::SumW'(m_gi_s4)
		- yba_pkg::SumW'(m_gq_s4);
	assign sum_b_w = yba_pkg::SumW'(ys_s4) - yba_pkg::SumW'(m_bi_s4)
		+ yba_pkg::SumW'(m_bq_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= yiq_valid;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && yiq_valid) begin
			ys_s4   <= yba_pkg::ScaledW'(base_w) <<< yba_pkg::CoefFracBits;
			m_ri_s4 <= yba_pkg::MixW'(yiq.chroma_i) * yba_pkg::MixW'(yba_pkg::CoefRI);
			m_rq_s4 <= yba_pkg::MixW'(yiq.chroma_q) * yba_pkg::MixW'(yba_pkg::CoefRQ);
			m_gi_s4 <= yba_pkg::MixW'(yiq.chroma_i) * yba_pkg::MixW'(yba_pkg::CoefGI);
			m_gq_s4 <= yba_pkg::MixW'(yiq.chroma_q) * yba_pkg::MixW'(yba_pkg::CoefGQ);
			m_bi_s4 <= yba_pkg::MixW'(yiq.chroma_i) * yba_pkg::MixW'(yba_pkg::CoefBI);
			m_bq_s4 <= yba_pkg::MixW'(yiq.chroma_q) * yba_pkg::MixW'(yba_pkg::CoefBQ);
			last_s4 <= yiq.last;
		end
		if (rdy_s5 && v_s4) begin
			res_s5.red_out   <= clamp_channel(sum_r_w);
			res_s5.green_out <= clamp_channel(sum_g_w);
			res_s5.blue_out  <= clamp_channel(sum_b_w);
			res_s5.last_out  <= last_s4;
		end
	end

	assign res_valid = v_s5;
	assign res       = res_s5;

endmodule

`default_nettype wire

/* design/yiq_brightness_adjust.sv */
// Brightness adjustment of an RGB pixel stream through the YIQ domain.
// Pixel channel: pixel_valid / pixel_ready / pixel; one 8-bit RGB pixel and a
//   frame end flag per transfer.
// Result channel: result_valid / result_ready / result; one adjusted pixel per
//   input pixel, in order, last_out copied from last_in.
// Config channel: cfg_valid / cfg_ready / cfg_data writes the signed luma
//   offset; cfg_ready is always high. Write it only while no pixel is in flight.
// Path: a pixel passes the stages s1 to s5 in order, and result_valid rises once
//   it is held in the output register of the last stage.
// Throughput: one pixel per cycle while result_ready is high; five pipeline
//   stages, each with its own valid bit; the last is the output register.
// Stall: when result_ready is low the result holds; earlier stages keep
//   filling bubbles, so pixel_ready falls only once every stage is occupied.
// Reset: arst_n clears all valid bits and sets the offset to 0.
`default_nettype none

module yiq_brightness_adjust (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pixel_valid,
	output logic                   pixel_ready,
	input  wire yba_pkg::pixel_t   pixel,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output yba_pkg::result_t       result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_data
);

	logic signed [7:0] brightness_q;
	logic          yiq_valid;
	logic          yiq_ready;
	yba_pkg::yiq_t yiq;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= 8'sd0;
		end else if (cfg_valid && cfg_ready) begin
			brightness_q <= $signed(cfg_data);
		end
	end

	yba_fwd u_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pixel_valid),
		.pix_ready (pixel_ready),
		.pix       (pixel),
		.yiq_valid (yiq_valid),
		.yiq_ready (yiq_ready),
		.yiq       (yiq)
	);

	yba_inv u_inv (
		.clk       (clk),
		.arst_n    (arst_n),
		.yiq_valid (yiq_valid),
		.yiq_ready (yiq_ready),
		.yiq       (yiq),
		.offset    (brightness_q),
		.res_valid (result_valid),
		.res_ready (result_ready),
		.res       (result)
	);

endmodule

`default_nettype wire

/* design/yba_checker.sv */
`default_nettype none

module yba_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             pixel_valid,
	input wire logic             pixel_ready,
	input wire logic             result_valid,
	input wire logic             result_ready,
	input wire yba_pkg::result_t result,
	input wire logic             cfg_ready
);

	logic [2:0] occ_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = pixel_valid && pixel_ready;
	assign out_xfer = result_valid && result_ready;

	// pixels in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 3'd0;
		end else begin
			occ_q <= occ_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> occ_q != 3'd0)
		else $error("result without a pending pixel");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 3'(yba_pkg::PipeDepth))
		else $error("more pixels in flight than pipeline stages");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == 3'd0 |-> pixel_ready && cfg_ready)
		else $error("empty pipeline refuses a transfer");

	a_ready_when_unstalled: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> pixel_ready)
		else $error("pixel_ready low while result side is ready");

endmodule

bind yiq_brightness_adjust yba_checker u_yba_checker (.*);

`default_nettype wire
